[rtl/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int WSD_QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  localparam logic [6:0] LEN7_MASK   = 7'h7F;
  localparam logic [6:0] LEN7_MAX    = 7'd125;
  localparam logic [6:0] LEN7_EXT16  = 7'd126;
  localparam logic [6:0] LEN7_EXT64  = 7'd127;
  localparam logic [7:0] RSV_MASK    = 8'h70;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } wsd_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
  } wsd_result_t;

  typedef struct packed {
    logic        push;
    wsd_result_t result;
  } wsd_emit_t;

endpackage

[rtl/wsd_parser.sv]
// ----------------------------------------------------------------------------
// wsd_parser
// Front end: header parse, key capture, payload unmask, one byte per cycle while accept is high.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  wsd_pkg::wsd_item_t item,
  output wsd_pkg::wsd_emit_t emit
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_SKIP = 3'd5
  } phase_t;

  phase_t      phase, phase_next, phase_eff;
  logic [3:0]  ext_left, ext_left_next;
  logic [63:0] rem, rem_next, rem_dec;
  logic [31:0] key, key_next, key_sh;
  logic [2:0]  key_left, key_left_next;
  logic [1:0]  midx, midx_next;
  logic [3:0]  opc, opc_next;
  logic        fin, fin_next;
  logic        masked, masked_next;
  logic        rejected, rejected_next;
  logic        len_done, hdr_done;
  logic [6:0]  len7;

  assign len7    = item.data_byte[6:0] & LEN7_MASK;
  assign rem_dec = (rem != 64'd0) ? rem - 64'd1 : rem;
  assign key_sh  = key << {midx, 3'b000};

  always_comb begin
    phase_next    = phase;
    ext_left_next = ext_left;
    rem_next      = rem;
    key_next      = key;
    key_left_next = key_left;
    midx_next     = midx;
    opc_next      = opc;
    fin_next      = fin;
    masked_next   = masked;
    rejected_next = rejected;
    len_done      = 1'b0;
    hdr_done      = 1'b0;
    emit          = '0;
    phase_eff     = item.frame_start ? PH_HDR0 : phase;

    case (phase_eff)
      PH_HDR1: begin
        masked_next = item.data_byte[7];
        if (len7 <= LEN7_MAX) begin
          rem_next = {57'd0, len7};
          len_done = 1'b1;
        end else begin
          rem_next      = 64'd0;
          ext_left_next = (len7 == LEN7_EXT16) ? 4'd2 : 4'd8;
          phase_next    = PH_EXT;
        end
      end
      PH_EXT: begin
        rem_next      = {rem[55:0], item.data_byte};
        ext_left_next = (ext_left != 4'd0) ? ext_left - 4'd1 : ext_left;
        len_done      = (ext_left_next == 4'd0);
      end
      PH_KEY: begin
        key_next      = {key[23:0], item.data_byte};
        key_left_next = (key_left != 3'd0) ? key_left - 3'd1 : key_left;
        hdr_done      = (key_left_next == 3'd0);
      end
      PH_DATA: begin
        midx_next               = midx + 2'd1;
        rem_next                = rem_dec;
        emit.push               = 1'b1;
        emit.result.out_byte    = masked ? (item.data_byte ^ key_sh[31:24])
                                         : item.data_byte;
        emit.result.kind        = KIND_PAYLOAD;
        emit.result.last        = (rem_dec == 64'd0);
        if (rem_dec == 64'd0) begin
          phase_next = PH_HDR0;
        end
      end
      PH_SKIP: begin
        rem_next = rem_dec;
        if (rem_dec == 64'd0) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        fin_next      = item.data_byte[7];
        opc_next      = item.data_byte[3:0];
        rejected_next = ((item.data_byte & RSV_MASK) != 8'd0);
        masked_next   = 1'b0;
        rem_next      = 64'd0;
        ext_left_next = 4'd0;
        key_left_next = 3'd0;
        midx_next     = 2'd0;
        phase_next    = PH_HDR1;
      end
    endcase

    if (len_done && masked_next) begin
      key_next      = 32'd0;
      key_left_next = 3'd4;
      phase_next    = PH_KEY;
    end else if (len_done || hdr_done) begin
      midx_next = 2'd0;
      if (rejected_next) begin
        phase_next       = (rem_next != 64'd0) ? PH_SKIP : PH_HDR0;
        emit.push        = 1'b1;
        emit.result.kind = KIND_REJECT;
        emit.result.last = 1'b1;
      end else if (rem_next == 64'd0) begin
        phase_next       = PH_HDR0;
        emit.push        = 1'b1;
        emit.result.kind = KIND_EMPTY;
        emit.result.last = 1'b1;
      end else begin
        phase_next = PH_DATA;
      end
    end

    emit.result.opcode = opc;
    emit.result.fin    = fin;
    emit.push          = emit.push & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HDR0;
      ext_left <= 4'd0;
      rem      <= 64'd0;
      key      <= 32'd0;
      key_left <= 3'd0;
      midx     <= 2'd0;
      opc      <= 4'd0;
      fin      <= 1'b0;
      masked   <= 1'b0;
      rejected <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      ext_left <= ext_left_next;
      rem      <= rem_next;
      key      <= key_next;
      key_left <= key_left_next;
      midx     <= midx_next;
      opc      <= opc_next;
      fin      <= fin_next;
      masked   <= masked_next;
      rejected <= rejected_next;
    end
  end

  a_nonpayload_last: assert property (@(posedge clk) disable iff (rst)
    emit.push && emit.result.kind != KIND_PAYLOAD |-> emit.result.last)
    else $error("header result without last");

  a_payload_in_data: assert property (@(posedge clk) disable iff (rst)
    emit.push && emit.result.kind == KIND_PAYLOAD |->
      phase == PH_DATA && !item.frame_start)
    else $error("payload emitted outside data phase");

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_SKIP && !item.frame_start |-> !emit.push)
    else $error("result emitted while skipping");

endmodule

[rtl/wsd_queue.sv]
// ----------------------------------------------------------------------------
// wsd_queue
// Back end: short result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
module wsd_queue #(
  parameter int DEPTH = wsd_pkg::WSD_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wsd_pkg::wsd_emit_t   emit,
  output logic                 full,
  output logic                 result_valid,
  input  logic                 result_stall,
  output wsd_pkg::wsd_result_t result
);
  import wsd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsd_result_t       slots [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;
  logic              pop;

  assign full         = (count == CW'(DEPTH));
  assign result_valid = (count != CW'(0));
  assign pop          = result_valid && !result_stall;
  assign result       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (emit.push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (emit.push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !emit.push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit.push) begin
      slots[wr_ptr] <= emit.result;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    emit.push |-> !full)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

[rtl/websocket_frame_deframer.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// RFC 6455 frame parser: header, extended length, mask key, unmasked payload.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while the result queue has room.
// Results are registered: each is written into the queue on the edge that accepts its byte.
// The queue of QUEUE_DEPTH entries absorbs output stall; input stalls when full.
// Reset (rst, synchronous): parser returns to header byte zero, queue empties.
module websocket_frame_deframer #(
  parameter int QUEUE_DEPTH = wsd_pkg::WSD_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  wsd_pkg::wsd_item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output wsd_pkg::wsd_result_t result
);
  import wsd_pkg::*;

  wsd_emit_t emit;
  logic      full;
  logic      accept;

  assign item_stall = full;
  assign accept     = item_valid && !full;

  wsd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .emit   (emit)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .emit         (emit),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
